// ===== hdl/rscc_pkg.sv =====
// Shared types, constants and helper functions for the RIFF/sfbk structure checker.
// Used by every module of the checker and by its configuration interface.
package rscc_pkg;

  localparam int unsigned MaxListDepthDef = 8;
  localparam int unsigned RecordBytes     = 46;
  localparam int unsigned TypeOffset      = RecordBytes - 2;
  localparam int unsigned PosW            = 33;
  localparam int unsigned CountW          = 17;
  localparam int unsigned MaxChunkW       = 16;
  localparam int unsigned MaxRecW         = 17;
  localparam int unsigned LimitW          = 23;
  localparam int unsigned CfgIdxW         = 4;
  localparam int unsigned CfgDataW        = 17;

  localparam logic [PosW-1:0]   PosMax   = '1;
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [MaxChunkW-1:0] MaxChunkRst = 16'd16384;
  // 65536 records of 46 bytes each
  localparam logic [LimitW-1:0]    ShdrLimitRst = 23'd3014656;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagSfbk = 32'h6B62_6673;
  localparam logic [31:0] TagList = 32'h5453_494C;
  localparam logic [31:0] TagInfo = 32'h4F46_4E49;
  localparam logic [31:0] TagSdta = 32'h6174_6473;
  localparam logic [31:0] TagPdta = 32'h6174_6470;
  localparam logic [31:0] TagIfil = 32'h6C69_6669;
  localparam logic [31:0] TagShdr = 32'h7264_6873;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_CHUNK_COUNT    = 4'd0,
    CFG_MAX_SAMPLE_RECORDS = 4'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_INFO  = 2'd1,
    KIND_PDTA  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_HDR_SHORT  = 3'd1,
    ST_BAD_TAG    = 3'd2,
    ST_BAD_SIZE   = 3'd3,
    ST_BAD_STRUCT = 3'd4
  } status_e;

  typedef enum logic [9:0] {
    PH_HDR     = 10'b00_0000_0001,
    PH_BETWEEN = 10'b00_0000_0010,
    PH_CHDR    = 10'b00_0000_0100,
    PH_LTYPE   = 10'b00_0000_1000,
    PH_IFIL    = 10'b00_0001_0000,
    PH_SHDR    = 10'b00_0010_0000,
    PH_SKIP    = 10'b00_0100_0000,
    PH_PAD     = 10'b00_1000_0000,
    PH_DONE    = 10'b01_0000_0000,
    PH_FAIL    = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    logic [MaxChunkW-1:0] max_chunk;
    logic [LimitW-1:0]    shdr_limit;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic        is_sf3;
    logic [15:0] major_version;
    logic [15:0] minor_version;
    logic        compressed;
  } result_t;

  // Remainder modulo 46 for values below 2^14: reciprocal multiply, then correct
  function automatic logic [5:0] red46(input logic [13:0] x);
    logic [28:0] prod;
    logic [8:0]  quo;
    logic [13:0] q46;
    logic [13:0] rem;
    prod = 29'(x) * 29'd22796;
    quo  = prod[28:20];
    q46  = (14'(quo) << 5) + (14'(quo) << 3) + (14'(quo) << 2) + (14'(quo) << 1);
    rem  = x - q46;
    return rem[5:0];
  endfunction

  // Byte weight of size byte i modulo 46: 1, 26, 32, 4
  function automatic logic [12:0] size_term(input logic [1:0] i, input logic [7:0] b);
    logic [12:0] w;
    w = 13'(b);
    case (i)
      2'd0:    return w;
      2'd1:    return (w << 4) + (w << 3) + (w << 1);
      2'd2:    return w << 5;
      default: return w << 2;
    endcase
  endfunction

endpackage

// ===== hdl/rscc_if.sv =====
// Valid/ready channel interfaces of the structure checker: byte input,
// result output and configuration writes. Depends on rscc_pkg.
interface rscc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rscc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        is_sf3;
  logic [15:0] major_version;
  logic [15:0] minor_version;
  logic        compressed;
  modport source (output valid, output status, output is_sf3, output major_version,
                  output minor_version, output compressed, input ready);
  modport sink   (input valid, input status, input is_sf3, input major_version,
                  input minor_version, input compressed, output ready);
endinterface

interface rscc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rscc_pkg::CfgIdxW-1:0]    index;
  logic [rscc_pkg::CfgDataW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rscc_cfg_regs.sv =====
// Configuration registers: chunk-count limit and the shdr byte limit derived
// from the sample-record limit. Depends on rscc_pkg and rscc_if.
module rscc_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  rscc_cfg_if.sink       cfg_i,
  output rscc_pkg::cfg_t cfg_o
);
  import rscc_pkg::*;

  logic [MaxChunkW-1:0] max_chunk_q;
  logic [LimitW-1:0]    shdr_limit_q;
  logic [LimitW-1:0]    limit_d;

  assign cfg_i.ready = 1'b1;

  // Records times 46 gives the largest shdr size in bytes
  assign limit_d = (LimitW'(cfg_i.data) << 5) + (LimitW'(cfg_i.data) << 3) +
                   (LimitW'(cfg_i.data) << 2) + (LimitW'(cfg_i.data) << 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chunk_q  <= MaxChunkRst;
      shdr_limit_q <= ShdrLimitRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MAX_CHUNK_COUNT:    max_chunk_q  <= cfg_i.data[MaxChunkW-1:0];
        CFG_MAX_SAMPLE_RECORDS: shdr_limit_q <= limit_d;
        default: ;
      endcase
    end
  end

  assign cfg_o.max_chunk  = max_chunk_q;
  assign cfg_o.shdr_limit = shdr_limit_q;

endmodule

// ===== hdl/rscc_parser.sv =====
// Per-byte chunk walker: parse state, list stack and the combinational next-state
// logic that yields a result on the last byte. Depends on rscc_pkg.
module rscc_parser #(
  parameter int unsigned MaxListDepth = rscc_pkg::MaxListDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_go_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  rscc_pkg::cfg_t    cfg_i,
  output rscc_pkg::result_t result_o
);
  import rscc_pkg::*;

  localparam int unsigned NumLvl = MaxListDepth + 1;
  localparam int unsigned LvlW   = $clog2(NumLvl);
  localparam logic [LvlW-1:0] LvlTop = LvlW'(MaxListDepth);

  logic [PosW-1:0]   pos_q, pos_d, decl_q, decl_d, cde_q, cde_d;
  logic [LvlW-1:0]   lvl_q, lvl_d;
  phase_e            phase_q, phase_d;
  logic [31:0]       word_q, word_d, tag_q, tag_d;
  logic              odd_q, odd_d, comp_q, comp_d;
  logic [CountW-1:0] seen_q, seen_d, seen_inc;
  logic [5:0]        rec_q, rec_d, rb, mod_q, mod_d, mod_new;
  logic [4:0]        sec_q, sec_d;
  logic [15:0]       major_q, major_d, minor_q, minor_d;
  status_e           err_q, err_d;

  logic [PosW-1:0]   end_q  [NumLvl];
  kind_e             kind_q [NumLvl];
  logic              pad_q  [NumLvl];

  logic [PosW-1:0]   q, e_top;
  logic [PosW:0]     q8, sum_end;
  kind_e             kind_top;
  logic [13:0]       mod_x;

  logic              push_en, push_pad, settle_en;
  logic [LvlW-1:0]   push_idx;
  logic [PosW-1:0]   push_end;
  kind_e             push_kind;
  logic [NumLvl-1:0] ge, near, pad_v;
  logic [PosW-1:0]   end_v [NumLvl];
  status_e           status;

  // Saturating position and helpers
  assign q        = (pos_q == PosMax) ? pos_q : pos_q + PosW'(1);
  assign q8       = {1'b0, q} + (PosW+1)'(8);
  assign word_d   = {data_byte_i, word_q[31:8]};
  assign rb       = rec_q + 6'd1;
  assign e_top    = end_q[lvl_q];
  assign kind_top = kind_q[lvl_q];
  assign sum_end  = {1'b0, q} + (PosW+1)'(word_d);
  assign seen_inc = (seen_q == CountMax) ? seen_q : seen_q + CountW'(1);

  // Running size remainder modulo 46, one size byte per cycle while item_go_i is high
  assign mod_x   = (rb == 6'd5) ? 14'(data_byte_i)
                                : 14'(mod_q) + 14'(size_term(2'(rb - 6'd5), data_byte_i));
  assign mod_new = red46(mod_x);

  always_comb begin
    logic active;
    pos_d     = q;
    decl_d    = decl_q;
    cde_d     = cde_q;
    lvl_d     = lvl_q;
    phase_d   = phase_q;
    tag_d     = tag_q;
    odd_d     = odd_q;
    comp_d    = comp_q;
    seen_d    = seen_q;
    rec_d     = rec_q;
    mod_d     = mod_q;
    sec_d     = sec_q;
    major_d   = major_q;
    minor_d   = minor_q;
    err_d     = err_q;
    push_en   = 1'b0;
    push_idx  = lvl_q;
    push_end  = cde_q;
    push_pad  = odd_q;
    push_kind = KIND_OTHER;
    settle_en = 1'b0;
    active    = 1'b0;

    // Per-phase byte action
    unique case (phase_q)
      PH_HDR: begin
        if (pos_q == PosW'(3)) tag_d = word_d;
        if (pos_q == PosW'(7)) decl_d = PosW'(word_d) + PosW'(8);
        if (pos_q == PosW'(11)) begin
          if (tag_q != TagRiff || word_d != TagSfbk) begin
            err_d   = ST_BAD_TAG;
            phase_d = PH_FAIL;
          end else if (decl_q < PosW'(12)) begin
            err_d   = ST_BAD_SIZE;
            phase_d = PH_FAIL;
          end else begin
            push_en   = 1'b1;
            push_idx  = '0;
            push_end  = decl_q;
            push_pad  = 1'b0;
            lvl_d     = '0;
            phase_d   = PH_BETWEEN;
            settle_en = 1'b1;
          end
        end
      end
      PH_CHDR: begin
        rec_d = rb;
        if (rb == 6'd4) tag_d = word_d;
        if (rb >= 6'd5) mod_d = mod_new;
        if (rb >= 6'd8) begin
          if (sum_end > {1'b0, e_top}) begin
            err_d = ST_BAD_STRUCT; phase_d = PH_FAIL;
          end else begin
            cde_d = sum_end[PosW-1:0];
            odd_d = word_d[0];
            rec_d = '0;
            if (word_d[0] && sum_end[PosW-1:0] >= e_top) begin
              err_d = ST_BAD_STRUCT; phase_d = PH_FAIL;
            end else if (tag_q == TagList) begin
              if (word_d < 32'd4) begin
                err_d = ST_BAD_STRUCT; phase_d = PH_FAIL;
              end else begin
                phase_d = PH_LTYPE;
              end
            end else if (tag_q == TagIfil && kind_top == KIND_INFO) begin
              if (word_d < 32'd4) begin
                err_d = ST_BAD_STRUCT; phase_d = PH_FAIL;
              end else begin
                phase_d = PH_IFIL;
              end
            end else if (tag_q == TagShdr && kind_top == KIND_PDTA) begin
              if (word_d < 32'(RecordBytes) || mod_new != 6'd0) begin
                err_d = ST_BAD_STRUCT; phase_d = PH_FAIL;
              end else begin
                sec_d = sec_q | 5'b10000;
                if (word_d > 32'(cfg_i.shdr_limit)) begin
                  err_d = ST_BAD_STRUCT; phase_d = PH_FAIL;
                end else begin
                  phase_d   = PH_SHDR;
                  settle_en = 1'b1;
                end
              end
            end else begin
              phase_d   = PH_SKIP;
              settle_en = 1'b1;
            end
          end
        end
      end
      PH_LTYPE: begin
        rec_d = rb;
        if (rb >= 6'd4) begin
          if (word_d == TagInfo) begin
            sec_d = sec_d | 5'b00001; push_kind = KIND_INFO;
          end
          if (word_d == TagSdta) sec_d = sec_d | 5'b00010;
          if (word_d == TagPdta) begin
            sec_d = sec_d | 5'b00100; push_kind = KIND_PDTA;
          end
          if (lvl_q == LvlTop) begin
            err_d = ST_BAD_STRUCT; phase_d = PH_FAIL;
          end else begin
            push_en   = 1'b1;
            push_idx  = lvl_q + LvlW'(1);
            lvl_d     = lvl_q + LvlW'(1);
            phase_d   = PH_BETWEEN;
            settle_en = 1'b1;
          end
        end
      end
      PH_IFIL: begin
        rec_d = rb;
        if (rb >= 6'd4) begin
          if (word_d[15:0] > major_q) major_d = word_d[15:0];
          minor_d   = word_d[31:16];
          sec_d     = sec_q | 5'b01000;
          phase_d   = PH_SKIP;
          settle_en = 1'b1;
        end
      end
      PH_SHDR: begin
        // Sample type of any record but the terminal one
        if (rec_q == 6'(TypeOffset) && ({1'b0, q} + (PosW+1)'(1)) < {1'b0, cde_q} &&
            data_byte_i[4]) begin
          comp_d = 1'b1;
        end
        rec_d     = (rb >= 6'(RecordBytes)) ? 6'd0 : rb;
        settle_en = 1'b1;
      end
      PH_SKIP: settle_en = 1'b1;
      PH_PAD: begin
        phase_d   = PH_BETWEEN;
        settle_en = 1'b1;
      end
      default: ;
    endcase

    // Stack view with this cycle's push folded in, compared in parallel
    for (int k = 0; k < NumLvl; k++) begin
      end_v[k] = (push_en && push_idx == LvlW'(k)) ? push_end : end_q[k];
      pad_v[k] = (push_en && push_idx == LvlW'(k)) ? push_pad : pad_q[k];
      ge[k]    = q >= end_v[k];
      near[k]  = q8 > {1'b0, end_v[k]};
    end

    // Close finished chunks and lists, then pad, finish, or open the next chunk header
    if (settle_en) begin
      if ((phase_d == PH_SKIP || phase_d == PH_SHDR) && q >= cde_d) begin
        phase_d = odd_d ? PH_PAD : PH_BETWEEN;
      end
      if (phase_d == PH_BETWEEN) begin
        active = 1'b1;
        for (int k = NumLvl - 1; k >= 0; k--) begin
          if (active && LvlW'(k) <= lvl_d) begin
            if (ge[k]) begin
              if (k == 0) begin
                phase_d = PH_DONE;
                active  = 1'b0;
              end else begin
                lvl_d = LvlW'(k - 1);
                if (pad_v[k]) begin
                  phase_d = PH_PAD;
                  active  = 1'b0;
                end
              end
            end else begin
              lvl_d  = LvlW'(k);
              seen_d = seen_inc;
              active = 1'b0;
              if (seen_inc > CountW'(cfg_i.max_chunk) || near[k]) begin
                err_d = ST_BAD_STRUCT; phase_d = PH_FAIL;
              end else begin
                phase_d = PH_CHDR;
                rec_d   = '0;
              end
            end
          end
        end
      end
    end
  end

  // Status on the final byte, by precedence
  always_comb begin
    if (q < PosW'(12)) status = ST_HDR_SHORT;
    else if (err_d == ST_BAD_TAG) status = ST_BAD_TAG;
    else if (err_d == ST_BAD_SIZE || decl_d > q) status = ST_BAD_SIZE;
    else if (err_d == ST_BAD_STRUCT || phase_d != PH_DONE || sec_d != 5'b11111)
      status = ST_BAD_STRUCT;
    else status = ST_OK;
  end

  assign result_o.status        = status;
  assign result_o.is_sf3        = (status == ST_OK) && (comp_d || major_d >= 16'd3);
  assign result_o.major_version = (status == ST_OK) ? major_d : 16'd0;
  assign result_o.minor_version = (status == ST_OK) ? minor_d : 16'd0;
  assign result_o.compressed    = (status == ST_OK) && comp_d;

  // Advance state; restart parsing after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; decl_q <= '0; cde_q <= '0; lvl_q <= '0; phase_q <= PH_HDR;
      word_q <= '0; tag_q <= '0; odd_q <= 1'b0; comp_q <= 1'b0; seen_q <= '0;
      rec_q <= '0; mod_q <= '0; sec_q <= '0; major_q <= '0; minor_q <= '0;
      err_q <= ST_OK;
    end else if (item_go_i) begin
      if (last_byte_i) begin
        pos_q <= '0; decl_q <= '0; cde_q <= '0; lvl_q <= '0; phase_q <= PH_HDR;
        word_q <= '0; tag_q <= '0; odd_q <= 1'b0; comp_q <= 1'b0; seen_q <= '0;
        rec_q <= '0; mod_q <= '0; sec_q <= '0; major_q <= '0; minor_q <= '0;
        err_q <= ST_OK;
      end else begin
        pos_q <= pos_d; decl_q <= decl_d; cde_q <= cde_d; lvl_q <= lvl_d;
        phase_q <= phase_d; word_q <= word_d; tag_q <= tag_d; odd_q <= odd_d;
        comp_q <= comp_d; seen_q <= seen_d; rec_q <= rec_d; mod_q <= mod_d;
        sec_q <= sec_d; major_q <= major_d; minor_q <= minor_d; err_q <= err_d;
      end
    end
  end

  // Push a list level
  always_ff @(posedge clk_i) begin
    if (item_go_i && push_en) begin
      end_q[push_idx]  <= push_end;
      kind_q[push_idx] <= push_kind;
      pad_q[push_idx]  <= push_pad;
    end
  end

`ifndef SYNTHESIS
  a_lvl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LvlTop) else $error("list level beyond depth");
  a_err_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ST_OK) |-> (phase_q == PH_FAIL)) else $error("error without fail phase");
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_go_i && last_byte_i) |=> (phase_q == PH_HDR && pos_q == '0))
    else $error("no restart after final byte");
  a_rec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_q < 6'(RecordBytes)) else $error("record byte out of range");
  a_done_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) |-> (pos_q >= decl_q)) else $error("done before declared end");
`endif

endmodule

// ===== hdl/rscc_result_reg.sv =====
// Output register for one result item with valid/ready handshake.
// Depends on rscc_pkg and rscc_if.
module rscc_result_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rscc_pkg::result_t result_i,
  output logic              free_o,
  rscc_out_if.source        out_o
);
  import rscc_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o = !valid_q || out_o.ready;

  // Hold until taken; load a new item when free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) res_q <= result_i;
  end

  assign out_o.valid         = valid_q;
  assign out_o.status        = res_q.status;
  assign out_o.is_sf3        = res_q.is_sf3;
  assign out_o.major_version = res_q.major_version;
  assign out_o.minor_version = res_q.minor_version;
  assign out_o.compressed    = res_q.compressed;

endmodule

// ===== hdl/riff_soundfont_structure_checker.sv =====
// RIFF/sfbk SoundFont structure checker, one file byte per item.
// A result becomes valid once its last byte is in the input register and the
// parse logic has loaded the output register from it; a full output register can
// hold the final byte back in between. Throughput: 1 byte per cycle, as the parse
// logic handles each byte combinationally; a pending result stalls only final bytes.
// Reset (rst_ni, async low) clears parse state and restores register defaults.
module riff_soundfont_structure_checker #(
  parameter int unsigned MAX_LIST_DEPTH = rscc_pkg::MaxListDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rscc_in_if.sink     in_i,
  rscc_out_if.source  out_o,
  rscc_cfg_if.sink    cfg_i
);
  import rscc_pkg::*;

  logic       s1_valid_q, s1_last_q;
  logic [7:0] s1_byte_q;
  logic       item_go, out_free;
  cfg_t       cfg;
  result_t    result;

  // Process the held byte unless it is a final byte facing a full output
  assign item_go    = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || item_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  rscc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  rscc_parser #(
    .MaxListDepth (MAX_LIST_DEPTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_go_i   (item_go),
    .data_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .cfg_i       (cfg),
    .result_o    (result)
  );

  rscc_result_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (item_go && s1_last_q),
    .result_i (result),
    .free_o   (out_free),
    .out_o    (out_o)
  );

endmodule
